@@ rtl/mte_pkg.sv @@
// ============================================================================
// mte_pkg : shared types and constants for the motion-to-expression block
// Command/status structs, step codes, register indexes and fixed widths.
// ============================================================================
`default_nettype none

package mte_pkg;

   // Request / result payload widths
   localparam int AXIS_W     = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int PB_W       = 14;
   localparam int CTL_W      = 7;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   typedef logic [CSR_IDX_W-1:0] reg_index_type;

   localparam reg_index_type REG_HOLD_SAMPLES  = 3'd0;
   localparam reg_index_type REG_VELOCITY_GAIN = 3'd1;
   localparam reg_index_type REG_CUTOFF_OFFSET = 3'd2;
   localparam reg_index_type REG_FLIP_X        = 3'd3;
   localparam reg_index_type REG_FLIP_Y        = 3'd4;
   localparam reg_index_type REG_SWAP_XY       = 3'd5;

   localparam logic [6:0] HOLD_SAMPLES_RESET  = 7'd50;
   localparam logic [7:0] VELOCITY_GAIN_RESET = 8'd4;

   // Arithmetic constants
   localparam int MUL_W      = 18;
   localparam int PROD_W     = 36;
   localparam int ROOT_STEPS = 8;

   // Step counter (covers sqrt steps and up to 32 window entries)
   localparam int CNT_W = 5;

   // Datapath step codes
   localparam int OP_W = 4;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_NONE   = 4'd0;
   localparam op_type OP_LOAD   = 4'd1;
   localparam op_type OP_SQX    = 4'd2;
   localparam op_type OP_SQY    = 4'd3;
   localparam op_type OP_SQZ    = 4'd4;
   localparam op_type OP_SCX    = 4'd5;
   localparam op_type OP_SCY    = 4'd6;
   localparam op_type OP_PB     = 4'd7;
   localparam op_type OP_CO     = 4'd8;
   localparam op_type OP_ROOT   = 4'd9;
   localparam op_type OP_UPDATE = 4'd10;
   localparam op_type OP_SCAN   = 4'd11;
   localparam op_type OP_PEAK   = 4'd12;
   localparam op_type OP_PROD   = 4'd13;
   localparam op_type OP_VEL    = 4'd14;
   localparam op_type OP_EMIT   = 4'd15;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

   typedef struct packed {
      logic [6:0]        hold_samples;
      logic [7:0]        velocity_gain;
      logic signed [8:0] cutoff_offset;
      logic              flip_x;
      logic              flip_y;
      logic              swap_xy;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/mte_ctrl.sv @@
// ============================================================================
// mte_ctrl : sequencer for the motion-to-expression datapath
// Steps one request through squares, scaling, maps, root, window scan, emit.
// ============================================================================
`default_nettype none

module mte_ctrl #(
   parameter int WINDOW_LEN = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  mte_pkg::status_type      status,
   output mte_pkg::cmd_type         cmd
);
   import mte_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQX  = 4'd1;
   localparam logic [3:0] S_SQY  = 4'd2;
   localparam logic [3:0] S_SQZ  = 4'd3;
   localparam logic [3:0] S_SCX  = 4'd4;
   localparam logic [3:0] S_SCY  = 4'd5;
   localparam logic [3:0] S_PB   = 4'd6;
   localparam logic [3:0] S_CO   = 4'd7;
   localparam logic [3:0] S_ROOT = 4'd8;
   localparam logic [3:0] S_UPD  = 4'd9;
   localparam logic [3:0] S_SCAN = 4'd10;
   localparam logic [3:0] S_PEAK = 4'd11;
   localparam logic [3:0] S_PROD = 4'd12;
   localparam logic [3:0] S_VEL  = 4'd13;
   localparam logic [3:0] S_EMIT = 4'd14;

   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW_LEN - 1);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   op_type           op;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign cmd.op     = op;
   assign cmd.count  = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op       = OP_LOAD;
               state_in = S_SQX;
            end
         end
         S_SQX: begin op = OP_SQX; state_in = S_SQY; end
         S_SQY: begin op = OP_SQY; state_in = S_SQZ; end
         S_SQZ: begin op = OP_SQZ; state_in = S_SCX; end
         S_SCX: begin op = OP_SCX; state_in = S_SCY; end
         S_SCY: begin op = OP_SCY; state_in = S_PB;  end
         S_PB:  begin op = OP_PB;  state_in = S_CO;  end
         S_CO: begin
            op       = OP_CO;
            state_in = S_ROOT;
            cnt_in   = '0;
         end
         S_ROOT: begin
            op = OP_ROOT;
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_UPD;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_UPD: begin
            op       = OP_UPDATE;
            state_in = S_SCAN;
            cnt_in   = '0;
         end
         S_SCAN: begin
            op = OP_SCAN;
            if (cnt_ff == SCAN_LAST) begin
               state_in = S_PEAK;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PEAK: begin op = OP_PEAK; state_in = S_PROD; end
         S_PROD: begin op = OP_PROD; state_in = S_VEL;  end
         S_VEL:  begin op = OP_VEL;  state_in = S_EMIT; end
         S_EMIT: begin
            // hold here while the previous result still sits in the output reg
            if (!status.out_full) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mte_dp.sv @@
// ============================================================================
// mte_dp : datapath for the motion-to-expression block
// Shared 18x18 multiplier, bit-pair square root, change window, output reg.
// ============================================================================
`default_nettype none

module mte_dp #(
   parameter int WINDOW_LEN = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  mte_pkg::cmd_type                      cmd,
   input  mte_pkg::cfg_type                      cfg,
   input  wire logic signed [mte_pkg::AXIS_W-1:0] raw_x,
   input  wire logic signed [mte_pkg::AXIS_W-1:0] raw_y,
   input  wire logic signed [mte_pkg::AXIS_W-1:0] raw_z,
   output mte_pkg::status_type                   status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [mte_pkg::PB_W-1:0]              rsp_pitch_bend,
   output logic [mte_pkg::CTL_W-1:0]             rsp_cutoff,
   output logic [mte_pkg::CTL_W-1:0]             rsp_velocity
);
   import mte_pkg::*;

   localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(WINDOW_LEN - 1);

   function automatic logic [16:0] abs17(input logic [AXIS_W-1:0] v);
      logic [16:0] ext;
      ext = {v[AXIS_W-1], v};
      return v[AXIS_W-1] ? (~ext + 17'd1) : ext;
   endfunction

   // clamp(p >> 8) to [0, 16383]
   function automatic logic [PB_W-1:0] map_pb(input logic [PROD_W-1:0] p);
      logic [PB_W-1:0] r;
      if (p[PROD_W-1])
         r = '0;
      else if (p[PROD_W-2:8+PB_W] != '0)
         r = '1;
      else
         r = p[8+PB_W-1:8];
      return r;
   endfunction

   // clamp(p >> 8) to [0, 127]
   function automatic logic [CTL_W-1:0] map_ctl(input logic [PROD_W-1:0] p);
      logic [CTL_W-1:0] r;
      if (p[PROD_W-1])
         r = '0;
      else if (p[PROD_W-2:8+CTL_W] != '0)
         r = '1;
      else
         r = p[8+CTL_W-1:8];
      return r;
   endfunction

   // input latch
   logic [AXIS_W-1:0] rx_ff, ry_ff, rz_ff;

   // working registers
   logic [15:0]       acc_ff, acc_in;
   logic [15:0]       rad_ff, rad_in;
   logic [8:0]        rem_ff, rem_in;
   logic [7:0]        root_ff, root_in;
   logic signed [8:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [PB_W-1:0]   pb_ff, pb_in;
   logic [CTL_W-1:0]  co_ff, co_in, vel_ff, vel_in;
   logic [14:0]       prod_ff, prod_in;
   logic [7:0]        best_ff, best_in;

   // running state
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        win_ff [WINDOW_LEN];
   logic [7:0]        win_in [WINDOW_LEN];
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [7:0]        peak_ff, peak_in;
   logic [6:0]        hold_ff, hold_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PB_W-1:0]   rsp_pb_ff;
   logic [CTL_W-1:0]  rsp_co_ff, rsp_vel_ff;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [15:0]              p_hi;
   logic [PROD_W-1:0]        scaled;

   // orientation
   logic signed [8:0] fx, fy, ox, oy;

   // root step
   logic [10:0] rem_sh, trial;

   // window update
   logic [7:0]  chg, rd, new_peak;
   logic [6:0]  hold_next;

   assign fx = cfg.flip_x ? -sx_ff : sx_ff;
   assign fy = cfg.flip_y ? -sy_ff : sy_ff;
   assign ox = cfg.swap_xy ? fy : fx;
   assign oy = cfg.swap_xy ? fx : fy;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SQX: begin mul_a = {1'b0, abs17(rx_ff)}; mul_b = {1'b0, abs17(rx_ff)}; end
         OP_SQY: begin mul_a = {1'b0, abs17(ry_ff)}; mul_b = {1'b0, abs17(ry_ff)}; end
         OP_SQZ: begin mul_a = {1'b0, abs17(rz_ff)}; mul_b = {1'b0, abs17(rz_ff)}; end
         OP_SCX: begin mul_a = {{2{rx_ff[AXIS_W-1]}}, rx_ff}; mul_b = 18'sd493; end
         OP_SCY: begin mul_a = {{2{ry_ff[AXIS_W-1]}}, ry_ff}; mul_b = 18'sd493; end
         OP_PB: begin
            mul_a = {{9{ox[8]}}, ox} + 18'd128;
            mul_b = 18'sd16383;
         end
         OP_CO: begin
            mul_a = {{9{cfg.cutoff_offset[8]}}, cfg.cutoff_offset}
                  + {{9{oy[8]}}, oy} + 18'd128;
            mul_b = 18'sd127;
         end
         OP_PROD: begin mul_a = {10'b0, peak_ff}; mul_b = {10'b0, cfg.velocity_gain}; end
         OP_VEL: begin
            mul_a = {3'b0, prod_ff} + 18'd128;
            mul_b = 18'sd127;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign p_hi   = mul_p[31:16];
   // truncate toward zero on the >> 16
   assign scaled = mul_p + (mul_p[PROD_W-1] ? PROD_W'(65535) : '0);

   assign rem_sh = {rem_ff, rad_ff[15:14]};
   assign trial  = {1'b0, root_ff, 2'b01};

   assign chg       = (root_ff >= prev_ff) ? (root_ff - prev_ff) : (prev_ff - root_ff);
   assign rd        = win_ff[cmd.count[IDX_W-1:0]];
   assign new_peak  = (best_ff > peak_ff) ? best_ff : peak_ff;
   assign hold_next = hold_ff + 7'd1;

   assign status.out_full = rsp_valid_ff && !rsp_ready;

   always_comb begin
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      pb_in        = pb_ff;
      co_in        = co_ff;
      vel_in       = vel_ff;
      prod_in      = prod_ff;
      best_in      = best_ff;
      prev_in      = prev_ff;
      win_in       = win_ff;
      pos_in       = pos_ff;
      peak_in      = peak_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         OP_SQX: acc_in = p_hi;
         OP_SQY: acc_in = acc_ff + p_hi;
         OP_SQZ: begin
            rad_in  = acc_ff + p_hi;
            rem_in  = '0;
            root_in = '0;
         end
         OP_SCX: sx_in = scaled[24:16];
         OP_SCY: sy_in = scaled[24:16];
         OP_PB:  pb_in = map_pb(mul_p);
         OP_CO:  co_in = map_ctl(mul_p);
         OP_ROOT: begin
            rad_in = {rad_ff[13:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = 9'(rem_sh - trial);
               root_in = {root_ff[6:0], 1'b1};
            end else begin
               rem_in  = rem_sh[8:0];
               root_in = {root_ff[6:0], 1'b0};
            end
         end
         OP_UPDATE: begin
            win_in[pos_ff] = chg;
            prev_in        = root_ff;
            pos_in         = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
            best_in        = '0;
         end
         OP_SCAN: best_in = (rd > best_ff) ? rd : best_ff;
         OP_PEAK: begin
            if (hold_next == cfg.hold_samples) begin
               for (int i = 0; i < WINDOW_LEN; i++) win_in[i] = '0;
               pos_in  = '0;
               peak_in = '0;
               hold_in = '0;
            end else begin
               peak_in = new_peak;
               hold_in = hold_next;
            end
         end
         OP_PROD: prod_in = (mul_p[PROD_W-2:15] != '0) ? 15'h7fff : mul_p[14:0];
         OP_VEL:  vel_in  = map_ctl(mul_p);
         OP_EMIT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         pos_ff       <= '0;
         peak_ff      <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
      end else begin
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         peak_ff      <= peak_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= win_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         rx_ff <= raw_x;
         ry_ff <= raw_y;
         rz_ff <= raw_z;
      end
      if (cmd.op == OP_EMIT) begin
         rsp_pb_ff  <= pb_ff;
         rsp_co_ff  <= co_ff;
         rsp_vel_ff <= vel_ff;
      end
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      pb_ff   <= pb_in;
      co_ff   <= co_in;
      vel_ff  <= vel_in;
      prod_ff <= prod_in;
      best_ff <= best_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pitch_bend = rsp_pb_ff;
   assign rsp_cutoff     = rsp_co_ff;
   assign rsp_velocity   = rsp_vel_ff;

endmodule

`default_nettype wire

@@ rtl/accel_motion_to_expression.sv @@
// ============================================================================
// accel_motion_to_expression : accelerometer sample to expression controls
// Maps tilt to pitch bend and cutoff, and motion peaks to velocity.
// ============================================================================
// Usage:
//  - req_* stream: one request per accelerometer sample (x, y, z, signed).
//  - rsp_* stream: exactly one result per request, in order.
//  - csr_* port: register writes (0 hold_samples, 1 velocity_gain,
//    2 cutoff_offset, 3 flip_x, 4 flip_y, 5 swap_xy); other indexes ignored.
//    Write only while no request is in flight. csr_ready is high out of reset.
//  - Operation: each accepted request is worked through one shared 18x18
//    multiplier (9 products), an 8-step bit-pair square root and a
//    one-entry-per-cycle scan of the change window, then rsp_tvalid rises.
//  - One request at a time: req_tready is high only between requests, so a
//    new request is taken only after the last one has reached its final step.
//  - The result sits in an output register; a stalled receiver holds it,
//    and the next request is still taken and worked on. It only waits at the
//    final step if the previous result has not been taken yet.
//  - Reset (synchronous): registers back to defaults, window, peak, hold
//    counter and previous magnitude cleared, no result pending.
// ============================================================================
`default_nettype none

module accel_motion_to_expression #(
   parameter int WINDOW_LEN = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mte_pkg::REQ_DATA_W-1:0]     req_tdata,  // raw_x, raw_y, raw_z
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mte_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // pitch_bend, cutoff,
                                                               // velocity, zero pad
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mte_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mte_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   logic [PB_W-1:0]  pitch_bend;
   logic [CTL_W-1:0] cutoff, velocity;

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HOLD_SAMPLES:  cfg_in.hold_samples  = csr_data[6:0];
            REG_VELOCITY_GAIN: cfg_in.velocity_gain = csr_data[7:0];
            REG_CUTOFF_OFFSET: cfg_in.cutoff_offset = csr_data;
            REG_FLIP_X:        cfg_in.flip_x        = csr_data[0];
            REG_FLIP_Y:        cfg_in.flip_y        = csr_data[0];
            REG_SWAP_XY:       cfg_in.swap_xy       = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_samples  <= HOLD_SAMPLES_RESET;
         cfg_ff.velocity_gain <= VELOCITY_GAIN_RESET;
         cfg_ff.cutoff_offset <= '0;
         cfg_ff.flip_x        <= 1'b0;
         cfg_ff.flip_y        <= 1'b0;
         cfg_ff.swap_xy       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and datapath
   // ---------------------------------------------------------------------
   mte_ctrl #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mte_dp #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg_ff),
      .raw_x          (req_tdata[15:0]),
      .raw_y          (req_tdata[31:16]),
      .raw_z          (req_tdata[47:32]),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_pitch_bend (pitch_bend),
      .rsp_cutoff     (cutoff),
      .rsp_velocity   (velocity)
   );

   // result packing: pitch_bend [13:0], cutoff [20:14], velocity [27:21]
   assign rsp_tdata = {4'b0, velocity, cutoff, pitch_bend};

endmodule

`default_nettype wire

@@ rtl/mte_checker.sv @@
// ============================================================================
// mte_props : port-level checks for accel_motion_to_expression
// Reset, one-at-a-time sequencing and result hold under stall.
// ============================================================================
`default_nettype none

module mte_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one in flight");

   // a new result only appears from the final step, never from idle
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while block idle");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind accel_motion_to_expression mte_props u_mte_props (.*);

`default_nettype wire

@@ bench/mte_checker.sv @@
// ============================================================================
// mte_checker : result predictor and scoreboard for accel_motion_to_expression
// Watches the request, result and register channels, keeps its own copy of
// the motion state and registers, and compares every result field by field.
// ============================================================================
`default_nettype none

module mte_checker #(
   parameter int WINDOW_LEN = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [mte_pkg::REQ_DATA_W-1:0] req_tdata,  // raw_x, raw_y, raw_z
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [mte_pkg::RSP_DATA_W-1:0] rsp_tdata,  // pitch_bend, cutoff,
                                                           // velocity, zero pad
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [mte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mte_pkg::CSR_DATA_W-1:0] csr_data,
   output int unsigned                         mismatches,
   output int unsigned                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import mte_pkg::*;

   // first member sits in the top bits, so pitch_bend lands at bit 0
   typedef struct packed {
      logic [CTL_W-1:0] velocity;
      logic [CTL_W-1:0] cutoff;
      logic [PB_W-1:0]  pitch_bend;
   } controls_t;

   cfg_type     cfg;
   logic [7:0]  last_magnitude;
   logic [7:0]  change_window [WINDOW_LEN];
   int          window_slot;
   logic [7:0]  held_peak;
   logic [6:0]  hold_count;
   controls_t   expected_controls [$];

   function automatic int clamp_to(input int v, input int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic int unsigned axis_energy(input logic signed [AXIS_W-1:0] a);
      int unsigned m;
      m = (a < 0) ? int'(-int'(a)) : int'(a);
      return (m * m) >> 16;
   endfunction

   // floor square root, bit by bit from the top; the sum stays below 2^16
   function automatic logic [7:0] floor_root(input int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 7; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return 8'(root);
   endfunction

   function automatic void clear_hold();
      foreach (change_window[i]) change_window[i] = '0;
      window_slot = 0;
      held_peak   = '0;
      hold_count  = '0;
   endfunction

   function automatic void write_register(input reg_index_type idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_HOLD_SAMPLES:  cfg.hold_samples  = value[6:0];
         REG_VELOCITY_GAIN: cfg.velocity_gain = value[7:0];
         REG_CUTOFF_OFFSET: cfg.cutoff_offset = value;
         REG_FLIP_X:        cfg.flip_x        = value[0];
         REG_FLIP_Y:        cfg.flip_y        = value[0];
         REG_SWAP_XY:       cfg.swap_xy       = value[0];
         default: ;  // spare indexes have no register
      endcase
   endfunction

   // advance the motion state by one sample and work out its controls
   function automatic controls_t predict_controls(input logic [REQ_DATA_W-1:0] sample);
      logic signed [AXIS_W-1:0] rx, ry, rz;
      int          sx, sy, swap_tmp, prod;
      logic [7:0]  mag, change, widest;
      controls_t   result;
      rx = sample[15:0];
      ry = sample[31:16];
      rz = sample[47:32];
      sx = (int'(rx) * 493) / 65536;
      sy = (int'(ry) * 493) / 65536;

      mag    = floor_root(axis_energy(rx) + axis_energy(ry) + axis_energy(rz));
      change = (mag > last_magnitude) ? mag - last_magnitude : last_magnitude - mag;
      last_magnitude = mag;

      change_window[window_slot] = change;
      window_slot = (window_slot == WINDOW_LEN - 1) ? 0 : window_slot + 1;
      widest = '0;
      foreach (change_window[i])
         if (change_window[i] > widest) widest = change_window[i];
      if (widest > held_peak) held_peak = widest;
      hold_count = hold_count + 7'd1;  // wraps at 128, so hold 0 clears too
      if (hold_count == cfg.hold_samples) clear_hold();

      if (cfg.flip_x) sx = -sx;
      if (cfg.flip_y) sy = -sy;
      if (cfg.swap_xy) begin
         swap_tmp = sx;
         sx = sy;
         sy = swap_tmp;
      end

      prod = int'(held_peak) * int'(cfg.velocity_gain);
      if (prod > 32767) prod = 32767;
      result.pitch_bend = PB_W'(clamp_to((sx + 128) * 16383 / 256, 16383));
      result.cutoff = CTL_W'(clamp_to(
         (int'($signed(cfg.cutoff_offset)) + sy + 128) * 127 / 256, 127));
      result.velocity = CTL_W'(clamp_to((prod + 128) * 127 / 256, 127));
      return result;
   endfunction

   always @(posedge clock) begin
      controls_t want;
      controls_t got;
      if (reset) begin
         cfg.hold_samples  = HOLD_SAMPLES_RESET;
         cfg.velocity_gain = VELOCITY_GAIN_RESET;
         cfg.cutoff_offset = '0;
         cfg.flip_x        = 1'b0;
         cfg.flip_y        = 1'b0;
         cfg.swap_xy       = 1'b0;
         last_magnitude    = '0;
         clear_hold();
         expected_controls.delete();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            expected_controls.push_back(predict_controls(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(controls_t)-1:0];
            if (expected_controls.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, got);
               mismatches++;
            end else begin
               want = expected_controls.pop_front();
               if (got.pitch_bend !== want.pitch_bend) begin
                  $display("%0t: pitch_bend expected %0d actual %0d",
                           $time, want.pitch_bend, got.pitch_bend);
                  mismatches++;
               end
               if (got.cutoff !== want.cutoff) begin
                  $display("%0t: cutoff expected %0d actual %0d",
                           $time, want.cutoff, got.cutoff);
                  mismatches++;
               end
               if (got.velocity !== want.velocity) begin
                  $display("%0t: velocity expected %0d actual %0d",
                           $time, want.velocity, got.velocity);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_controls.size();
   end

endmodule

`default_nettype wire

@@ bench/tb_accel_motion_to_expression.sv @@
// ============================================================================
// tb_accel_motion_to_expression : top-level bench for the motion block
// Drives accelerometer samples and register writes through several phases
// of settings and back-pressure; the checker beside the block scores results.
// ============================================================================
`default_nettype none

module tb_accel_motion_to_expression;
   timeunit 1ns;
   timeprecision 1ps;

   import mte_pkg::*;

   localparam int WINDOW_LEN  = 10;
   localparam int CYCLE_LIMIT = 400_000;

   // indexes past the last register; the block must ignore writes to them
   localparam reg_index_type REG_SPARE_LO = 3'd6;
   localparam reg_index_type REG_SPARE_HI = 3'd7;

   // back-pressure modes, cycled through from phase to phase
   typedef enum int {
      PRESS_NONE,
      PRESS_SENDER,
      PRESS_RECEIVER,
      PRESS_BOTH
   } pressure_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // raw_x, raw_y, raw_z
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // pitch_bend, cutoff, velocity, pad
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   reg_index_type         csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int          sender_idle_pct  = 0;
   int          receiver_stall_pct = 0;

   always #5 clock = ~clock;

   accel_motion_to_expression #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mte_checker #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // receiver: one decision per edge, so tready never gets two updates a step
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_sample(input int x, input int y,
                                                          input int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [AXIS_W-1:0] pick_extreme();
      case ($urandom_range(4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mix of full-range noise, near-rest readings (tiny magnitudes and
   // changes), rail-to-rail swings (big peaks) and plausible tilt
   function automatic logic [REQ_DATA_W-1:0] random_sample();
      int kind;
      kind = $urandom_range(99);
      if (kind < 40)
         return {16'($urandom), 16'($urandom), 16'($urandom)};
      else if (kind < 65)
         return pack_sample(int'($urandom_range(600)) - 300,
                            int'($urandom_range(600)) - 300,
                            int'($urandom_range(600)) - 300);
      else if (kind < 85)
         return {pick_extreme(), pick_extreme(), pick_extreme()};
      else
         return pack_sample(int'($urandom_range(40000)) - 20000,
                            int'($urandom_range(40000)) - 20000,
                            16384 + int'($urandom_range(4000)) - 2000);
   endfunction

   function automatic void set_pressure(input pressure_t mode);
      case (mode)
         PRESS_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         PRESS_SENDER:   begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
         PRESS_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
         default:        begin sender_idle_pct = 23; receiver_stall_pct = 23; end
      endcase
   endfunction

   // one request; returns in the step of the accepting edge, nothing driven yet
   task automatic send_sample(input logic [REQ_DATA_W-1:0] sample);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // csr_valid stays up between writes of a batch; caller drops it
   task automatic write_register(input reg_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop requests and let every result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_sample(random_sample());
   endtask

   // all six registers at random, full 9-bit data so unused bits toggle too
   task automatic shuffle_registers();
      if ($urandom_range(1))
         write_register(REG_HOLD_SAMPLES, {2'($urandom), 7'($urandom_range(1, 12))});
      else
         write_register(REG_HOLD_SAMPLES, 9'($urandom));
      write_register(REG_VELOCITY_GAIN, 9'($urandom));
      write_register(REG_CUTOFF_OFFSET, 9'($urandom));
      write_register(REG_FLIP_X, 9'($urandom));
      write_register(REG_FLIP_Y, 9'($urandom));
      write_register(REG_SWAP_XY, 9'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset settings, no back-pressure ---
      set_pressure(PRESS_NONE);
      send_sample(pack_sample(0, 0, 0));               // zero magnitude
      send_sample(pack_sample(32767, 32767, 32767));   // biggest jump, high clamps
      send_sample(pack_sample(-32768, -32768, -32768)); // low clamps
      send_sample(pack_sample(0, 0, 0));
      send_sample(pack_sample(32767, -32768, 0));
      send_sample(pack_sample(-32768, 32767, 0));
      send_sample(pack_sample(133, -133, 0));          // scaling just reaches one
      send_sample(pack_sample(132, -132, 1));          // truncates back to zero
      send_sample(pack_sample(-1, -1, -1));
      send_sample(pack_sample(1, 1, 1));
      send_sample(pack_sample(0, 0, 256));             // smallest nonzero square
      send_sample(pack_sample(0, 0, 255));
      send_sample(pack_sample(0, 0, -32768));
      send_sample(pack_sample(-17017, 17017, 16384));  // around pitch bend floor
      send_sample(pack_sample(-17554, 17554, -16384));
      send_sample(pack_sample(17554, -17554, 16384));  // around pitch bend ceiling
      send_sample(pack_sample(-32768, 0, 32767));
      send_sample(pack_sample(0, 32767, 0));
      drain();

      // --- long hold, full gain so the peak product saturates, all flips ---
      write_register(REG_HOLD_SAMPLES, 9'd127);
      write_register(REG_VELOCITY_GAIN, 9'd255);
      write_register(REG_CUTOFF_OFFSET, 9'h100);      // -256
      write_register(REG_FLIP_X, 9'd1);
      write_register(REG_FLIP_Y, 9'd1);
      write_register(REG_SWAP_XY, 9'd1);
      csr_valid <= 1'b0;
      set_pressure(PRESS_SENDER);
      send_sample(pack_sample(0, 0, 0));
      send_sample(pack_sample(32767, 32767, 32767));
      send_random(50);
      drain();

      // --- clear every item, zero gain, top offset; upper data bits set ---
      write_register(REG_HOLD_SAMPLES, 9'h181);       // low bits give 1
      write_register(REG_VELOCITY_GAIN, 9'h100);      // low bits give 0
      write_register(REG_CUTOFF_OFFSET, 9'h0FF);      // +255
      write_register(REG_FLIP_X, 9'h1FE);
      write_register(REG_FLIP_Y, 9'h1FE);
      write_register(REG_SWAP_XY, 9'h1FE);
      csr_valid <= 1'b0;
      set_pressure(PRESS_RECEIVER);
      send_random(40);
      drain();

      // --- hold of zero: clears only after the counter wraps; spare indexes ---
      write_register(REG_HOLD_SAMPLES, 9'h180);
      write_register(REG_VELOCITY_GAIN, 9'd128);
      write_register(REG_SPARE_LO, 9'($urandom));
      write_register(REG_SPARE_HI, 9'($urandom));
      write_register(REG_CUTOFF_OFFSET, 9'($urandom));
      write_register(REG_SWAP_XY, 9'd0);
      csr_valid <= 1'b0;
      set_pressure(PRESS_BOTH);
      send_random(60);
      drain();

      // --- hold lowered below the running count: runs on, wraps, then clears ---
      write_register(REG_HOLD_SAMPLES, 9'd3);
      write_register(REG_SPARE_HI, 9'h1FF);
      csr_valid <= 1'b0;
      set_pressure(PRESS_NONE);
      send_random(90);
      drain();

      // --- random settings under each kind of back-pressure ---
      for (int phase = 0; phase < 4; phase++) begin
         shuffle_registers();
         set_pressure(pressure_t'(phase));
         send_random(40);
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
